>>> design/weighted_unit_service_scheduler_macros.svh
// Assertion helpers shared by the scheduler modules.
`ifndef WEIGHTED_UNIT_SERVICE_SCHEDULER_MACROS_SVH
`define WEIGHTED_UNIT_SERVICE_SCHEDULER_MACROS_SVH

// Assert that a condition implies another one in the same cycle.
`define WUSS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Assert that a condition implies another one in the next cycle.
`define WUSS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> design/wuss_pkg.sv
package wuss_pkg;

  localparam int HeapDepth = 1024;
  localparam int AddrW = $clog2(HeapDepth);
  localparam int CountW = AddrW + 1;
  localparam int CostW = 42;
  localparam int QueueDepth = 2;
  localparam int QueueAw = $clog2(QueueDepth);

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic        kind;
    logic [15:0] units;
    logic [15:0] weight;
  } req_t;

  // One result request.
  typedef struct packed {
    logic              refused;
    logic              served;
    logic [15:0]       served_weight;
    logic [15:0]       served_left;
    logic [10:0]       pending_jobs;
    logic [CostW-1:0]  outstanding_cost;
  } res_t;

endpackage

>>> design/wuss_front.sv
module wuss_front
  import wuss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_req
);

  req_t                entries [QueueDepth];
  logic [QueueAw-1:0]  wr_ptr;
  logic [QueueAw-1:0]  rd_ptr;
  logic [QueueAw:0]    fill;

  logic push;
  logic pop;

  assign in_ready = (fill != (QueueAw+1)'(QueueDepth));
  assign q_valid = (fill != '0);
  assign q_req = entries[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  // Request queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_req;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

>>> design/wuss_back.sv
`include "weighted_unit_service_scheduler_macros.svh"

module wuss_back
  import wuss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_ready,
  input  req_t  q_req,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_UPRD  = 10'b0000000010,
    S_UPCMP = 10'b0000000100,
    S_TKRD  = 10'b0000001000,
    S_TKCMP = 10'b0000010000,
    S_TKLD  = 10'b0000100000,
    S_DNRD  = 10'b0001000000,
    S_DNR2  = 10'b0010000000,
    S_DNCMP = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  logic [31:0] mem [HeapDepth];
  logic [31:0] rdata;
  logic [AddrW-1:0] raddr;
  logic         re;
  logic [AddrW-1:0] waddr;
  logic [31:0]  wdata;
  logic         we;

  logic [CountW-1:0] count;
  logic [CostW-1:0]  cost;
  logic [31:0]       cur;
  logic [CountW-1:0] pos;
  logic [31:0]       lval;
  logic [CountW:0]   lc;
  logic [CountW:0]   rc;
  logic [CountW-1:0] parent;
  logic [CountW-1:0] last;
  logic [31:0]       prod;
  logic              prod_pend;
  logic [31:0]       lbest;
  logic [CountW-1:0] lbest_pos;

  assign lc = {pos, 1'b1};
  assign rc = lc + 1'b1;
  assign parent = (pos - 1'b1) >> 1;
  assign last = count - 1'b1;
  assign q_ready = (state == S_IDLE) && !res_valid;

  // Heap memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Read and write address selection for each step of the sift.
  always_comb begin
    re = 1'b0;
    raddr = '0;
    we = 1'b0;
    waddr = pos[AddrW-1:0];
    wdata = cur;
    unique case (state)
      S_UPRD: begin
        re = 1'b1;
        raddr = parent[AddrW-1:0];
      end
      S_UPCMP: begin
        we = 1'b1;
        if (pos != '0 && rdata < cur) wdata = rdata;
      end
      S_TKRD: begin
        re = 1'b1;
        raddr = '0;
      end
      S_TKCMP: begin
        re = 1'b1;
        raddr = last[AddrW-1:0];
      end
      S_DNRD: begin
        re = 1'b1;
        raddr = lc[AddrW-1:0];
      end
      S_DNR2: begin
        re = 1'b1;
        raddr = rc[AddrW-1:0];
      end
      S_DNCMP: begin
        we = 1'b1;
        wdata = lbest;
      end
      default: ;
    endcase
  end

  // Pick the larger child among those inside the heap.
  always_comb begin
    lbest = cur;
    lbest_pos = pos;
    if (lc < {1'b0, count} && lval > lbest) begin
      lbest = lval;
      lbest_pos = lc[CountW-1:0];
    end
    if (rc < {1'b0, count} && rdata > lbest) begin
      lbest = rdata;
      lbest_pos = rc[CountW-1:0];
    end
  end

  // Control sequencer: classify, sift, and deliver one result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cost <= '0;
      res_valid <= 1'b0;
      prod_pend <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            res.refused <= 1'b0;
            res.served <= 1'b0;
            res.served_weight <= '0;
            res.served_left <= '0;
            if (q_req.kind == KIND_ARRIVAL) begin
              if (q_req.units == '0 || count == CountW'(HeapDepth)) begin
                res.refused <= 1'b1;
                state <= S_DONE;
              end else begin
                cur <= {q_req.weight, q_req.units};
                pos <= count;
                count <= count + 1'b1;
                prod <= 32'(q_req.units) * 32'(q_req.weight);
                prod_pend <= 1'b1;
                state <= S_UPRD;
              end
            end else if (count == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_TKRD;
            end
          end
        end
        S_UPRD: begin
          // The new job's cost is added once, on the first level.
          if (prod_pend) begin
            cost <= cost + CostW'(prod);
            prod_pend <= 1'b0;
          end
          state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (pos != '0 && rdata < cur) begin
            pos <= parent;
            state <= S_UPRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_TKRD: state <= S_TKCMP;
        S_TKCMP: begin
          // The root is in rdata; serve one unit of it.
          res.served <= 1'b1;
          res.served_weight <= rdata[31:16];
          cost <= cost - CostW'(rdata[31:16]);
          pos <= '0;
          if (rdata[15:0] > 16'd1) begin
            cur <= {rdata[31:16], rdata[15:0] - 16'd1};
            res.served_left <= rdata[15:0] - 16'd1;
            state <= S_DNRD;
          end else begin
            count <= count - 1'b1;
            if (count == CountW'(1)) state <= S_DONE;
            else state <= S_TKLD;
          end
        end
        S_TKLD: begin
          // The last entry moves to the root and sifts down.
          cur <= rdata;
          state <= S_DNRD;
        end
        S_DNRD: state <= S_DNR2;
        S_DNR2: begin
          lval <= rdata;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (lbest_pos != pos) begin
            pos <= lbest_pos;
            state <= S_DNRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          res.pending_jobs <= 11'(count);
          res.outstanding_cost <= cost;
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WUSS_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CountW'(HeapDepth))
  `WUSS_ASSERT_IMP(a_no_accept_busy, clk, rst, res_valid, !q_ready)
  `WUSS_ASSERT_IMP(a_tick_nonempty, clk, rst, state == S_TKRD, count != '0)
  `WUSS_ASSERT_NEXT(a_done_out, clk, rst, state == S_DONE, res_valid)

endmodule

>>> design/weighted_unit_service_scheduler.sv
// Weighted unit service scheduler.
// Input stream s_axis: tdata carries job_units (bits 15:0) and job_weight
// (bits 31:16); tuser carries kind (0 arrival, 1 tick).
// Output stream m_axis: one result request per input request.
// An arrival sifts up through the heap memory, reading the parent and
// then comparing and writing at each level; a tick reads the root and
// sifts down, reading both children and then comparing and writing.
// The time from input acceptance to m_axis_tvalid is set by the sift
// depth of the 1024-entry heap memory with its registered read port; a
// refused arrival or a tick on an empty heap does not sift.
// The back part starts a new request only once m_axis has taken its
// result, so items are handled one at a time.
// A two-entry queue in front accepts requests while the back part works.
// A result waits in the output register while m_axis_tready is low; the
// back part then takes no new request, and the queue fills and stalls.
// Reset (rst, synchronous) empties the heap, cost and queue; heap memory
// contents are not cleared, and entries outside the heap are never used.
module weighted_unit_service_scheduler
  import wuss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // job_units[15:0], job_weight[31:16]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // served_weight, served_left, pending_jobs, cost
  output logic [1:0]  m_axis_tuser   // refused, served
);

  req_t in_req;
  req_t q_req;
  logic q_valid;
  logic q_ready;
  res_t res;

  assign in_req.kind = s_axis_tuser;
  assign in_req.units = s_axis_tdata[15:0];
  assign in_req.weight = s_axis_tdata[31:16];

  wuss_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  wuss_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tuser = {res.served, res.refused};
  assign m_axis_tdata = {3'd0, res.outstanding_cost, res.pending_jobs,
                         res.served_left, res.served_weight};

endmodule
